// ===== rtl/rsw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rsw_pkg;

   localparam int unsigned MAX_WINDOW = 64;
   localparam int unsigned SEQ_W      = 32;
   localparam int unsigned CSR_W      = 7;

   // command codes on req_cmd
   localparam logic CMD_CHECK   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [CSR_W-1:0] WINDOW_RESET = 7'd50;

   // both queues between and behind the two halves
   localparam int unsigned PTR_W = 2;
   localparam int unsigned CNT_W = PTR_W + 1;
   localparam logic [CNT_W-1:0] QUEUE_DEPTH = 3'd4;

   typedef struct packed {
      logic             is_release;
      logic [SEQ_W-1:0] seq;
   } rsw_item_type;

   typedef struct packed {
      logic take;
      logic res_full;
   } rsw_back_status_type;

endpackage

`default_nettype wire

// ===== rtl/replay_sequence_window_unit.sv =====
// Anti-replay window for call sequence numbers.
// Input queue: drive req_cmd (0 check, 1 release) and req_seq with req_push;
// the item is taken at a clock edge where req_push is high and req_full low.
// Result queue: while rsp_empty is low, rsp_accepted holds the oldest result;
// rsp_pop at such an edge removes it. Every item gives exactly one result,
// in order.
// An item waits in the input queue until the back half executes it, and its
// result is registered into the result queue. Throughput: one item per cycle
// while the result queue has room or is popped. The window update (32-bit
// subtracts, 64-bit shifts and a bit test) is combinational in the back half.
// A four-entry queue sits on each side; when the receiver stops popping, the
// result queue fills, the back half stops and the input queue fills behind it
// until req_full rises. Nothing is dropped.
// csr_wdata with csr_we sets the window size (0 acts as 1, above 64 acts as
// 64); write it only while the block is idle.
// Reset (synchronous, active high) empties both queues, sets the largest
// sequence seen to 0, clears every valid bit and sets the window size to 50.
`timescale 1ns / 1ps
`default_nettype none

module replay_sequence_window_unit (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_push,
   output logic                         req_full,
   input  wire                          req_cmd,
   input  wire  [rsw_pkg::SEQ_W-1:0]    req_seq,
   output logic                         rsp_empty,
   input  wire                          rsp_pop,
   output logic                         rsp_accepted,
   input  wire                          csr_we,
   input  wire  [rsw_pkg::CSR_W-1:0]    csr_wdata
);

   logic                         item_valid;
   logic                         item_take;
   rsw_pkg::rsw_item_type        item;
   rsw_pkg::rsw_back_status_type status;

   rsw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_cmd    (req_cmd),
      .req_seq    (req_seq),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   rsw_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .item_valid   (item_valid),
      .item         (item),
      .item_take    (item_take),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_accepted (rsp_accepted),
      .status       (status)
   );

   a_take_needs_item: assert property (@(posedge clock) disable iff (reset)
      status.take |-> item_valid)
      else $error("back half took an item from an empty queue");

   a_no_idle_back: assert property (@(posedge clock) disable iff (reset)
      (item_valid && !status.res_full) |-> status.take)
      else $error("back half stalled with room for a result");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      status.take |=> !rsp_empty)
      else $error("executed item left no result");

   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> (rsp_empty && !req_full && !item_valid))
      else $error("queues not empty after reset");

endmodule

`default_nettype wire

// ===== rtl/rsw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsw_front (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_push,
   output logic                           req_full,
   input  wire                            req_cmd,
   input  wire  [rsw_pkg::SEQ_W-1:0]      req_seq,
   output logic                           item_valid,
   output rsw_pkg::rsw_item_type          item,
   input  wire                            item_take
);

   rsw_pkg::rsw_item_type           queue_ff [rsw_pkg::QUEUE_DEPTH];
   logic [rsw_pkg::PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [rsw_pkg::PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [rsw_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                            push_ok;
   rsw_pkg::rsw_item_type           incoming;

   assign req_full   = (count_ff == rsw_pkg::QUEUE_DEPTH);
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];
   assign push_ok    = req_push && !req_full;

   always_comb begin
      incoming.is_release = (req_cmd == rsw_pkg::CMD_RELEASE);
      incoming.seq        = req_seq;
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = item_take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !item_take) begin
         count_in = count_ff + 1'b1;
      end else if (!push_ok && item_take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rsw_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsw_back (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_we,
   input  wire  [rsw_pkg::CSR_W-1:0]      csr_wdata,
   input  wire                            item_valid,
   input  rsw_pkg::rsw_item_type          item,
   output logic                           item_take,
   output logic                           rsp_empty,
   input  wire                            rsp_pop,
   output logic                           rsp_accepted,
   output rsw_pkg::rsw_back_status_type   status
);

   // window mask from the written size: zero acts as one, saturate at the bitmap width
   function automatic logic [rsw_pkg::MAX_WINDOW-1:0] size_mask(
      input logic [rsw_pkg::CSR_W-1:0] size
   );
      logic [rsw_pkg::MAX_WINDOW-1:0] m;
      if (size == '0) begin
         m = {{(rsw_pkg::MAX_WINDOW-1){1'b0}}, 1'b1};
      end else if (size >= rsw_pkg::CSR_W'(rsw_pkg::MAX_WINDOW)) begin
         m = '1;
      end else begin
         m = ({{(rsw_pkg::MAX_WINDOW-1){1'b0}}, 1'b1} << size[5:0]) - 1'b1;
      end
      return m;
   endfunction

   logic [rsw_pkg::MAX_WINDOW-1:0]  mask_ff;
   logic [rsw_pkg::SEQ_W-1:0]       largest_ff, largest_in;
   logic [rsw_pkg::MAX_WINDOW-1:0]  bits_ff, bits_in;

   logic                            res_ff [rsw_pkg::QUEUE_DEPTH];
   logic [rsw_pkg::PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [rsw_pkg::PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [rsw_pkg::CNT_W-1:0]       count_ff, count_in;

   logic                            res_full;
   logic                            pop_ok;
   logic                            ahead;
   logic [rsw_pkg::SEQ_W-1:0]       fwd_dist;
   logic [rsw_pkg::SEQ_W-1:0]       back_dist;
   logic                            far_jump;
   logic                            in_bitmap;
   logic [rsw_pkg::MAX_WINDOW-1:0]  shifted;
   logic [rsw_pkg::MAX_WINDOW-1:0]  new_ones;
   logic                            hit;

   assign res_full  = (count_ff == rsw_pkg::QUEUE_DEPTH);
   assign pop_ok    = rsp_pop && !rsp_empty;
   assign item_take = item_valid && (!res_full || pop_ok);
   assign rsp_empty = (count_ff == '0);
   assign rsp_accepted = res_ff[rd_ptr_ff];

   assign status.take     = item_take;
   assign status.res_full = res_full;

   always_comb begin
      ahead     = (item.seq > largest_ff);
      fwd_dist  = item.seq - largest_ff;
      back_dist = largest_ff - item.seq;
      far_jump  = |fwd_dist[rsw_pkg::SEQ_W-1:6];
      in_bitmap = !ahead && !(|back_dist[rsw_pkg::SEQ_W-1:6]);
      shifted   = far_jump ? '0 : (bits_ff << fwd_dist[5:0]);
      new_ones  = far_jump ? '1 :
                  ({{(rsw_pkg::MAX_WINDOW-1){1'b0}}, 1'b1} << fwd_dist[5:0]) - 1'b1;

      largest_in = largest_ff;
      bits_in    = bits_ff;
      hit        = 1'b0;
      if (!item.is_release && ahead) begin
         // advance: the new largest lands on bit 0, always inside the window
         largest_in = item.seq;
         bits_in    = (shifted | new_ones) & mask_ff;
         hit        = 1'b1;
      end else if (in_bitmap) begin
         hit = bits_ff[back_dist[5:0]];
         if (item.is_release) begin
            bits_in[back_dist[5:0]] = 1'b0;
         end
      end

      wr_ptr_in = item_take ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (item_take && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (!item_take && pop_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff    <= size_mask(rsw_pkg::WINDOW_RESET);
         largest_ff <= '0;
         bits_ff    <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         if (csr_we) begin
            mask_ff <= size_mask(csr_wdata);
         end
         if (item_take) begin
            largest_ff <= largest_in;
            bits_ff    <= bits_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         res_ff[wr_ptr_ff] <= hit;
      end
   end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PHASES      = 8;
   localparam int unsigned PHASE_ITEMS = 138;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic                      cmd;
      logic [rsw_pkg::SEQ_W-1:0] seq;
      logic                      typed;
      logic                      accepted;
   } stim_row_type;

   typedef struct packed {
      logic                      cmd;
      logic [rsw_pkg::SEQ_W-1:0] seq;
      logic                      accepted;
   } verdict_type;

   logic                      clock        = 1'b0;
   logic                      reset        = 1'b1;
   logic                      req_push     = 1'b0;
   logic                      req_cmd      = rsw_pkg::CMD_CHECK;
   logic [rsw_pkg::SEQ_W-1:0] req_seq      = '0;
   logic                      rsp_pop      = 1'b0;
   logic                      csr_we       = 1'b0;
   logic [rsw_pkg::CSR_W-1:0] csr_wdata    = '0;
   wire                       req_full;
   wire                       rsp_empty;
   wire                       rsp_accepted;

   idle_mode_type    idle_mode    = IDLE_NONE;
   verdict_type      verdict_q[$];
   int unsigned      error_count  = 0;
   int unsigned      cycle_count  = 0;

   // window model
   logic [rsw_pkg::CSR_W-1:0] win_size;
   logic [rsw_pkg::SEQ_W-1:0] win_top;
   logic [63:0]               win_bits;

   // window is 50 after reset; typed rows can be read off directly
   stim_row_type lead_rows [21] = '{
      '{rsw_pkg::CMD_CHECK,   32'd0,          1'b1, 1'b0},   // sequence zero never valid
      '{rsw_pkg::CMD_RELEASE, 32'd0,          1'b1, 1'b0},
      '{rsw_pkg::CMD_CHECK,   32'd1,          1'b1, 1'b1},
      '{rsw_pkg::CMD_CHECK,   32'd1,          1'b1, 1'b1},
      '{rsw_pkg::CMD_RELEASE, 32'd1,          1'b1, 1'b1},
      '{rsw_pkg::CMD_RELEASE, 32'd1,          1'b1, 1'b0},
      '{rsw_pkg::CMD_CHECK,   32'd1,          1'b1, 1'b0},
      '{rsw_pkg::CMD_RELEASE, 32'd5,          1'b1, 1'b0},   // ahead of the window
      '{rsw_pkg::CMD_CHECK,   32'd64,         1'b0, 1'b0},   // jump of 63 keeps old bits
      '{rsw_pkg::CMD_CHECK,   32'd14,         1'b0, 1'b0},
      '{rsw_pkg::CMD_CHECK,   32'd15,         1'b0, 1'b0},
      '{rsw_pkg::CMD_CHECK,   32'd128,        1'b1, 1'b1},   // jump of 64 clears all
      '{rsw_pkg::CMD_CHECK,   32'd65,         1'b0, 1'b0},
      '{rsw_pkg::CMD_RELEASE, 32'd128,        1'b1, 1'b1},
      '{rsw_pkg::CMD_CHECK,   32'd128,        1'b1, 1'b0},
      '{rsw_pkg::CMD_RELEASE, 32'd129,        1'b1, 1'b0},
      '{rsw_pkg::CMD_CHECK,   32'h7FFF_FFF0,  1'b1, 1'b1},
      '{rsw_pkg::CMD_RELEASE, 32'h7FFF_FFBF,  1'b0, 1'b0},
      '{rsw_pkg::CMD_RELEASE, 32'h7FFF_FFBE,  1'b1, 1'b0},   // behind the window
      '{rsw_pkg::CMD_CHECK,   32'd0,          1'b1, 1'b0},
      '{rsw_pkg::CMD_RELEASE, 32'h8000_0000,  1'b1, 1'b0}
   };

   // top of the sequence space, run last since largest seen never comes back down
   stim_row_type tail_rows [6] = '{
      '{rsw_pkg::CMD_CHECK,   32'hFFFF_FFFF,  1'b1, 1'b1},
      '{rsw_pkg::CMD_CHECK,   32'hFFFF_FFC0,  1'b0, 1'b0},
      '{rsw_pkg::CMD_RELEASE, 32'hFFFF_FFFF,  1'b1, 1'b1},
      '{rsw_pkg::CMD_CHECK,   32'hFFFF_FFFE,  1'b0, 1'b0},
      '{rsw_pkg::CMD_CHECK,   32'd0,          1'b1, 1'b0},
      '{rsw_pkg::CMD_RELEASE, 32'hFFFF_FFFF,  1'b1, 1'b0}
   };

   logic [rsw_pkg::CSR_W-1:0] phase_window [PHASES] = '{
      7'd50, 7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd17, 7'd33
   };

   replay_sequence_window_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_cmd      (req_cmd),
      .req_seq      (req_seq),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_accepted (rsp_accepted),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [63:0] ones_below(input logic [rsw_pkg::SEQ_W-1:0] n);
      if (n >= 64)
         return '1;
      return (64'd1 << n) - 64'd1;
   endfunction

   // advances the window on a check, then tests and maybe clears the item's bit
   function automatic logic window_verdict(input logic cmd,
                                           input logic [rsw_pkg::SEQ_W-1:0] seq);
      logic [rsw_pkg::SEQ_W-1:0] jump;
      logic [63:0]               shifted;
      logic [rsw_pkg::SEQ_W-1:0] span;
      logic                      hit;
      hit = 1'b0;
      if (cmd == rsw_pkg::CMD_CHECK && seq > win_top) begin
         jump    = seq - win_top;
         shifted = (jump >= 64) ? 64'd0 : (win_bits << jump);
         span    = (win_size == 0) ? 1 :
                   ((win_size > rsw_pkg::MAX_WINDOW) ? rsw_pkg::MAX_WINDOW : win_size);
         win_bits = (shifted | ones_below(jump)) & ones_below(span);
         win_top  = seq;
      end
      if (seq <= win_top && (win_top - seq) < 64) begin
         hit = win_bits[win_top - seq];
         if (cmd == rsw_pkg::CMD_RELEASE)
            win_bits[win_top - seq] = 1'b0;
      end
      return hit;
   endfunction

   function automatic int unsigned send_gap_pct(input idle_mode_type m);
      case (m)
         IDLE_SENDER: return 47;
         IDLE_BOTH:   return 20;
         default:     return 0;
      endcase
   endfunction

   function automatic int unsigned recv_stall_pct(input idle_mode_type m);
      case (m)
         IDLE_RECEIVER: return 47;
         IDLE_BOTH:     return 20;
         default:       return 0;
      endcase
   endfunction

   task automatic note_mismatch(input string what, input verdict_type v, input logic got);
      $display("[%0t] %s: cmd=%0d seq=%08h got=%b want=%b",
               $time, what, v.cmd, v.seq, got, v.accepted);
      error_count++;
   endtask

   // pushes one item and files its expected verdict once it is taken
   task automatic send_item(input logic cmd, input logic [rsw_pkg::SEQ_W-1:0] seq,
                            input logic typed, input logic typed_accepted);
      verdict_type v;
      logic        predicted;
      while ($urandom_range(0, 99) < send_gap_pct(idle_mode)) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_cmd  <= cmd;
      req_seq  <= seq;
      do
         @(posedge clock);
      while (req_full);
      predicted  = window_verdict(cmd, seq);
      v.cmd      = cmd;
      v.seq      = seq;
      v.accepted = typed ? typed_accepted : predicted;
      verdict_q.insert(verdict_q.size(), v);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (verdict_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_window(input logic [rsw_pkg::CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      win_size   = value;
   endtask

   always @(posedge clock) begin : take_results
      verdict_type v;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (verdict_q.size() == 0) begin
               v = '0;
               note_mismatch("result with nothing expected", v, rsp_accepted);
            end else begin
               v = verdict_q[0];
               verdict_q.delete(0);
               if (rsp_accepted !== v.accepted)
                  note_mismatch("accepted mismatch", v, rsp_accepted);
            end
         end
         rsp_pop <= ($urandom_range(0, 99) >= recv_stall_pct(idle_mode));
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int unsigned               roll;
      logic                      cmd;
      logic [rsw_pkg::SEQ_W-1:0] seq;
      win_size = rsw_pkg::WINDOW_RESET;
      win_top  = '0;
      win_bits = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (lead_rows[i])
         send_item(lead_rows[i].cmd, lead_rows[i].seq, lead_rows[i].typed,
                   lead_rows[i].accepted);

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         set_window((p == PHASES - 1) ? rsw_pkg::CSR_W'($urandom_range(2, 63))
                                      : phase_window[p]);
         idle_mode = idle_mode_type'(p % 4);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // hold off until the block has handed back everything
            if (i == PHASE_ITEMS / 2)
               wait_drained();
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
               cmd = rsw_pkg::CMD_CHECK;
               seq = win_top + $urandom_range(1, 4);
            end else if (roll < 50) begin
               cmd = rsw_pkg::CMD_CHECK;
               seq = win_top - $urandom_range(0, 70);
            end else if (roll < 80) begin
               cmd = rsw_pkg::CMD_RELEASE;
               seq = win_top - $urandom_range(0, 70);
            end else if (roll < 85) begin
               cmd = rsw_pkg::CMD_CHECK;
               seq = win_top + (roll[0] ? $urandom_range(60, 70) : $urandom_range(71, 100000));
            end else if (roll < 90) begin
               cmd = rsw_pkg::CMD_RELEASE;
               seq = win_top + $urandom_range(1, 10);
            end else begin
               cmd = 1'($urandom_range(0, 1));
               seq = $urandom;
            end
            send_item(cmd, seq, 1'b0, 1'b0);
         end
      end

      foreach (tail_rows[i])
         send_item(tail_rows[i].cmd, tail_rows[i].seq, tail_rows[i].typed,
                   tail_rows[i].accepted);

      wait_drained();
      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
